FILE: design/tlblru_pkg.sv
// Shared constants, command and result codes, and types of the two-level TLB.
package tlblru_pkg;

  localparam int FIRST_ENTRIES_DEF  = 16;
  localparam int SECOND_ENTRIES_DEF = 64;
  localparam int PAGE_BITS_DEF      = 12;
  localparam int VIRT_BITS_DEF      = 48;
  localparam int PHYS_BITS_DEF      = 40;

  // Width of the access clock and of every age stamp.
  localparam int STAMP_W = 64;

  typedef enum logic [1:0] {
    CMD_XLATE = 2'd0,
    CMD_INVAL = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_XLATE    = 2'd0,
    KIND_WALK     = 2'd1,
    KIND_WB       = 2'd2,
    KIND_INV_DONE = 2'd3
  } kind_t;

  // Control from the sequencer to the entry scanner.
  typedef struct packed {
    logic clr;  // restart the scan, forget all earlier entries
    logic vld;  // read data of one entry is present this cycle
  } scan_ctl_t;

endpackage

FILE: design/tlblru_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module tlblru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/tlblru_scan.sv
// Entry scanner: finds the first matching valid entry and the replacement choice.
module tlblru_scan import tlblru_pkg::*; #(
  parameter int IDX_W  = 6,
  parameter int TAG_W  = 36,
  parameter int WORD_W = 130
) (
  input  logic               clk,
  input  logic               rst_n,
  input  scan_ctl_t          ctl,
  input  logic [IDX_W-1:0]   idx,
  input  logic               ent_valid,
  input  logic [TAG_W-1:0]   ent_tag,
  input  logic [STAMP_W-1:0] ent_stamp,
  input  logic [WORD_W-1:0]  ent_word,
  input  logic [TAG_W-1:0]   key,
  output logic               hit,
  output logic [IDX_W-1:0]   hit_idx,
  output logic [WORD_W-1:0]  hit_word,
  output logic [IDX_W-1:0]   pick_idx,
  output logic [WORD_W-1:0]  pick_word
);

  logic               hit_r, hit_nxt;
  logic               have_r, have_nxt;
  logic               inval_r, inval_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [WORD_W-1:0]  hit_word_r, hit_word_nxt;
  logic [IDX_W-1:0]   pick_idx_r, pick_idx_nxt;
  logic [STAMP_W-1:0] pick_stamp_r, pick_stamp_nxt;
  logic [WORD_W-1:0]  pick_word_r, pick_word_nxt;
  logic               take;

  // An invalid entry wins at once; otherwise only a strictly older stamp
  // replaces the current choice, so the lowest index wins ties.
  assign take = ctl.vld &&
                (!have_r || (!inval_r && (!ent_valid || ent_stamp < pick_stamp_r)));

  always_comb begin
    hit_nxt        = hit_r;
    have_nxt       = have_r;
    inval_nxt      = inval_r;
    hit_idx_nxt    = hit_idx_r;
    hit_word_nxt   = hit_word_r;
    pick_idx_nxt   = pick_idx_r;
    pick_stamp_nxt = pick_stamp_r;
    pick_word_nxt  = pick_word_r;
    if (ctl.clr) begin
      hit_nxt   = 1'b0;
      have_nxt  = 1'b0;
      inval_nxt = 1'b0;
    end else begin
      if (ctl.vld && !hit_r && ent_valid && ent_tag == key) begin
        hit_nxt      = 1'b1;
        hit_idx_nxt  = idx;
        hit_word_nxt = ent_word;
      end
      if (take) begin
        have_nxt       = 1'b1;
        inval_nxt      = !ent_valid;
        pick_idx_nxt   = idx;
        pick_stamp_nxt = ent_stamp;
        pick_word_nxt  = ent_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 1'b0;
      have_r  <= 1'b0;
      inval_r <= 1'b0;
    end else begin
      hit_r   <= hit_nxt;
      have_r  <= have_nxt;
      inval_r <= inval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r    <= hit_idx_nxt;
    hit_word_r   <= hit_word_nxt;
    pick_idx_r   <= pick_idx_nxt;
    pick_stamp_r <= pick_stamp_nxt;
    pick_word_r  <= pick_word_nxt;
  end

  assign hit       = hit_r;
  assign hit_idx   = hit_idx_r;
  assign hit_word  = hit_word_r;
  assign pick_idx  = pick_idx_r;
  assign pick_word = pick_word_r;

endmodule

FILE: design/two_level_tlb_lru_writeback.sv
// Top level of the two-level fully associative TLB with LRU replacement and write-back.
//
// Both TLB levels live in synchronous RAMs, one word per slot holding valid, dirty, tag,
// frame and age stamp, and a single sequencer works on one input word at a time by
// scanning a level entry by entry through the RAM read port, then writing back the
// modified slots. A translation that hits the first level scans only that level, a
// first-level miss adds a second-level scan, a promotion that displaces a valid
// first-level slot adds one more second-level scan, and a fill scans the first level
// and up to twice the second level. An invalidate scans both levels. After reset the
// block clears both RAMs, one slot per cycle, and in_ready stays low during that
// pass. Each input word gives one to three result words; the last one carries
// out_last. Results leave through an output register, and cmd 3 is taken and
// dropped without any result.
module two_level_tlb_lru_writeback import tlblru_pkg::*; #(
  parameter int FIRST_ENTRIES  = FIRST_ENTRIES_DEF,
  parameter int SECOND_ENTRIES = SECOND_ENTRIES_DEF,
  parameter int PAGE_BITS      = PAGE_BITS_DEF,
  parameter int VIRT_BITS      = VIRT_BITS_DEF,
  parameter int PHYS_BITS      = PHYS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [47:0] in_virt_addr,
  input  logic        in_is_write,
  input  logic [27:0] in_fill_page,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [47:0] out_address,
  output logic        out_walk_write,
  output logic        out_hit_first,
  output logic        out_hit_second,
  output logic        out_last
);

  // Effective virtual width is capped by the 48-bit address port.
  localparam int VW      = (VIRT_BITS < 48) ? VIRT_BITS : 48;
  localparam int TAG_W   = VW - PAGE_BITS;
  localparam int FRAME_W = (PHYS_BITS - PAGE_BITS < 28) ? (PHYS_BITS - PAGE_BITS) : 28;
  localparam int WORD_W  = 2 + TAG_W + FRAME_W + STAMP_W;
  localparam int FR_LO   = STAMP_W;
  localparam int TG_LO   = STAMP_W + FRAME_W;
  localparam int IDX1_W  = (FIRST_ENTRIES > 1) ? $clog2(FIRST_ENTRIES) : 1;
  localparam int IDX2_W  = (SECOND_ENTRIES > 1) ? $clog2(SECOND_ENTRIES) : 1;
  localparam int SIDX_W  = (IDX1_W > IDX2_W) ? IDX1_W : IDX2_W;
  localparam int MAXN    = (FIRST_ENTRIES > SECOND_ENTRIES) ? FIRST_ENTRIES : SECOND_ENTRIES;
  localparam int CNT_W   = $clog2(MAXN + 1);
  localparam logic [CNT_W-1:0] N1_C    = CNT_W'(FIRST_ENTRIES);
  localparam logic [CNT_W-1:0] N2_C    = CNT_W'(SECOND_ENTRIES);
  localparam logic [CNT_W-1:0] MAXN_M1 = CNT_W'(MAXN - 1);
  localparam logic [63:0] VA_MASK64 = (64'd1 << VW) - 64'd1;
  localparam logic [47:0] VA_MASK   = VA_MASK64[47:0];
  localparam logic [63:0] PA_MASK   = (64'd1 << PHYS_BITS) - 64'd1;

  typedef enum logic [11:0] {
    S_CLEAR = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_SCAN  = 12'b0000_0000_0100,
    S_T1    = 12'b0000_0000_1000,
    S_T2    = 12'b0000_0001_0000,
    S_F1    = 12'b0000_0010_0000,
    S_INS1  = 12'b0000_0100_0000,
    S_PUSH  = 12'b0000_1000_0000,
    S_TOUCH = 12'b0001_0000_0000,
    S_F2    = 12'b0010_0000_0000,
    S_V1    = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  function automatic logic [WORD_W-1:0] w_pack(input logic v, input logic d,
                                               input logic [TAG_W-1:0] t,
                                               input logic [FRAME_W-1:0] f,
                                               input logic [STAMP_W-1:0] s);
    return {v, d, t, f, s};
  endfunction

  function automatic logic w_valid(input logic [WORD_W-1:0] w);
    return w[WORD_W-1];
  endfunction

  function automatic logic w_dirty(input logic [WORD_W-1:0] w);
    return w[WORD_W-2];
  endfunction

  function automatic logic [TAG_W-1:0] w_tag(input logic [WORD_W-1:0] w);
    return w[TG_LO +: TAG_W];
  endfunction

  function automatic logic [FRAME_W-1:0] w_frame(input logic [WORD_W-1:0] w);
    return w[FR_LO +: FRAME_W];
  endfunction

  function automatic logic [STAMP_W-1:0] w_stamp(input logic [WORD_W-1:0] w);
    return w[STAMP_W-1:0];
  endfunction

  function automatic logic [47:0] phys48(input logic [FRAME_W-1:0] fr,
                                         input logic [PAGE_BITS-1:0] o);
    logic [63:0] p;
    p = ((64'(fr) << PAGE_BITS) | 64'(o)) & PA_MASK;
    return p[47:0];
  endfunction

  // Sequencer registers.
  state_t               state_r, state_nxt;
  state_t               ret_r, ret_nxt;
  cmd_t                 op_r, op_nxt;
  logic                 lvl_r, lvl_nxt;
  logic [TAG_W-1:0]     key_r, key_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 dv_r, dv_nxt;
  logic [CNT_W-1:0]     di_r, di_nxt;
  logic [STAMP_W-1:0]   clock_r, clock_nxt;
  logic [TAG_W-1:0]     tag_r, tag_nxt;
  logic [PAGE_BITS-1:0] off_r, off_nxt;
  logic [47:0]          va_r, va_nxt;
  logic                 wr_r, wr_nxt;
  logic [FRAME_W-1:0]   fill_r, fill_nxt;
  logic [IDX1_W-1:0]    p1_idx_r, p1_idx_nxt;
  logic [WORD_W-1:0]    p1_word_r, p1_word_nxt;
  logic [IDX2_W-1:0]    j_idx_r, j_idx_nxt;
  logic [WORD_W-1:0]    j_word_r, j_word_nxt;
  logic [FRAME_W-1:0]   ins_frame_r, ins_frame_nxt;
  logic                 ins_dirty_r, ins_dirty_nxt;
  logic                 skip_touch_r, skip_touch_nxt;
  kind_t                fin_kind_r, fin_kind_nxt;
  logic [47:0]          fin_addr_r, fin_addr_nxt;
  logic                 fin_ww_r, fin_ww_nxt;
  logic                 fin_h1_r, fin_h1_nxt;
  logic                 fin_h2_r, fin_h2_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  kind_t                out_kind_r, out_kind_nxt;
  logic [47:0]          out_addr_r, out_addr_nxt;
  logic                 out_ww_r, out_ww_nxt;
  logic                 out_h1_r, out_h1_nxt;
  logic                 out_h2_r, out_h2_nxt;
  logic                 out_last_r, out_last_nxt;

  // RAM ports.
  logic                 w1_en, w2_en;
  logic [IDX1_W-1:0]    w1_addr;
  logic [IDX2_W-1:0]    w2_addr;
  logic [WORD_W-1:0]    w1_data, w2_data;
  logic [WORD_W-1:0]    rd1_word, rd2_word, sel_word;

  // Scanner.
  scan_ctl_t            sctl;
  logic                 s_hit;
  logic [SIDX_W-1:0]    s_hit_idx, s_pick_idx;
  logic [WORD_W-1:0]    s_hit_word, s_pick_word;

  // Combinational helpers.
  logic                 sc_go, sc_lvl;
  logic [TAG_W-1:0]     sc_key;
  state_t               sc_ret;
  logic                 em_req, em_ww, em_h1, em_h2, em_last;
  kind_t                em_kind;
  logic [47:0]          em_addr;
  logic                 out_free, wb;
  logic [CNT_W-1:0]     cur_n;
  logic [47:0]          va_m;
  logic [TAG_W-1:0]     in_tag;

  assign va_m     = in_virt_addr & VA_MASK;
  assign in_tag   = va_m[VW-1:PAGE_BITS];
  assign cur_n    = lvl_r ? N2_C : N1_C;
  assign sel_word = lvl_r ? rd2_word : rd1_word;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  tlblru_ram #(.WIDTH(WORD_W), .DEPTH(FIRST_ENTRIES)) u_first_ram (
    .clk     (clk),
    .wr_en   (w1_en),
    .wr_addr (w1_addr),
    .wr_data (w1_data),
    .rd_addr (cnt_r[IDX1_W-1:0]),
    .rd_data (rd1_word)
  );

  tlblru_ram #(.WIDTH(WORD_W), .DEPTH(SECOND_ENTRIES)) u_second_ram (
    .clk     (clk),
    .wr_en   (w2_en),
    .wr_addr (w2_addr),
    .wr_data (w2_data),
    .rd_addr (cnt_r[IDX2_W-1:0]),
    .rd_data (rd2_word)
  );

  assign sctl = '{clr: sc_go, vld: dv_r};

  tlblru_scan #(.IDX_W(SIDX_W), .TAG_W(TAG_W), .WORD_W(WORD_W)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sctl),
    .idx       (di_r[SIDX_W-1:0]),
    .ent_valid (w_valid(sel_word)),
    .ent_tag   (w_tag(sel_word)),
    .ent_stamp (w_stamp(sel_word)),
    .ent_word  (sel_word),
    .key       (key_r),
    .hit       (s_hit),
    .hit_idx   (s_hit_idx),
    .hit_word  (s_hit_word),
    .pick_idx  (s_pick_idx),
    .pick_word (s_pick_word)
  );

  // A dirty second-level slot that gets replaced is written back first.
  assign wb = !s_hit && w_valid(s_pick_word) && w_dirty(s_pick_word);

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    op_nxt         = op_r;
    lvl_nxt        = lvl_r;
    key_nxt        = key_r;
    cnt_nxt        = cnt_r;
    dv_nxt         = (state_r == S_SCAN) && (cnt_r != cur_n);
    di_nxt         = cnt_r;
    clock_nxt      = clock_r;
    tag_nxt        = tag_r;
    off_nxt        = off_r;
    va_nxt         = va_r;
    wr_nxt         = wr_r;
    fill_nxt       = fill_r;
    p1_idx_nxt     = p1_idx_r;
    p1_word_nxt    = p1_word_r;
    j_idx_nxt      = j_idx_r;
    j_word_nxt     = j_word_r;
    ins_frame_nxt  = ins_frame_r;
    ins_dirty_nxt  = ins_dirty_r;
    skip_touch_nxt = skip_touch_r;
    fin_kind_nxt   = fin_kind_r;
    fin_addr_nxt   = fin_addr_r;
    fin_ww_nxt     = fin_ww_r;
    fin_h1_nxt     = fin_h1_r;
    fin_h2_nxt     = fin_h2_r;
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_addr_nxt   = out_addr_r;
    out_ww_nxt     = out_ww_r;
    out_h1_nxt     = out_h1_r;
    out_h2_nxt     = out_h2_r;
    out_last_nxt   = out_last_r;
    w1_en          = 1'b0;
    w1_addr        = p1_idx_r;
    w1_data        = w_pack(1'b1, ins_dirty_r, tag_r, ins_frame_r, clock_r);
    w2_en          = 1'b0;
    w2_addr        = j_idx_r;
    w2_data        = '0;
    sc_go          = 1'b0;
    sc_lvl         = 1'b1;
    sc_key         = tag_r;
    sc_ret         = S_DONE;
    em_req         = 1'b0;
    em_kind        = KIND_WB;
    em_addr        = phys48(w_frame(s_pick_word), '0);
    em_ww          = 1'b0;
    em_h1          = 1'b0;
    em_h2          = 1'b0;
    em_last        = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        w1_en   = (cnt_r < N1_C);
        w1_addr = cnt_r[IDX1_W-1:0];
        w1_data = '0;
        w2_en   = (cnt_r < N2_C);
        w2_addr = cnt_r[IDX2_W-1:0];
        w2_data = '0;
        if (cnt_r == MAXN_M1) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid && in_cmd != CMD_NONE) begin
          clock_nxt    = clock_r + 1'b1;
          op_nxt       = cmd_t'(in_cmd);
          tag_nxt      = in_tag;
          off_nxt      = va_m[PAGE_BITS-1:0];
          va_nxt       = va_m;
          wr_nxt       = in_is_write;
          fill_nxt     = in_fill_page[FRAME_W-1:0];
          fin_kind_nxt = KIND_INV_DONE;
          fin_addr_nxt = '0;
          fin_ww_nxt   = 1'b0;
          fin_h1_nxt   = 1'b0;
          fin_h2_nxt   = 1'b0;
          sc_go        = 1'b1;
          sc_lvl       = 1'b0;
          sc_key       = in_tag;
          if (in_cmd == CMD_XLATE) begin
            sc_ret = S_T1;
          end else if (in_cmd == CMD_INVAL) begin
            sc_ret = S_V1;
          end else begin
            sc_ret = S_F1;
          end
        end
      end

      S_SCAN: begin
        if (cnt_r != cur_n) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          state_nxt = ret_r;
        end
        if (op_r == CMD_INVAL && dv_r && w_valid(sel_word) && w_tag(sel_word) == key_r) begin
          if (!lvl_r) begin
            w1_en   = 1'b1;
            w1_addr = di_r[IDX1_W-1:0];
            w1_data = {1'b0, sel_word[WORD_W-2:0]};
          end else begin
            w2_en   = 1'b1;
            w2_addr = di_r[IDX2_W-1:0];
            w2_data = {1'b0, sel_word[WORD_W-2:0]};
          end
        end
      end

      S_T1: begin
        if (s_hit) begin
          w1_en        = 1'b1;
          w1_addr      = s_hit_idx[IDX1_W-1:0];
          w1_data      = w_pack(1'b1, w_dirty(s_hit_word) | wr_r, w_tag(s_hit_word),
                                w_frame(s_hit_word), clock_r);
          fin_kind_nxt = KIND_XLATE;
          fin_addr_nxt = phys48(w_frame(s_hit_word), off_r);
          fin_ww_nxt   = 1'b0;
          fin_h1_nxt   = 1'b1;
          fin_h2_nxt   = 1'b0;
          state_nxt    = S_DONE;
        end else begin
          p1_idx_nxt  = s_pick_idx[IDX1_W-1:0];
          p1_word_nxt = s_pick_word;
          sc_go       = 1'b1;
          sc_ret      = S_T2;
        end
      end

      S_T2: begin
        if (!s_hit) begin
          fin_kind_nxt = KIND_WALK;
          fin_addr_nxt = va_r;
          fin_ww_nxt   = wr_r;
          fin_h1_nxt   = 1'b0;
          fin_h2_nxt   = 1'b0;
          state_nxt    = S_DONE;
        end else begin
          j_idx_nxt      = s_hit_idx[IDX2_W-1:0];
          j_word_nxt     = s_hit_word;
          ins_frame_nxt  = w_frame(s_hit_word);
          ins_dirty_nxt  = w_dirty(s_hit_word) | wr_r;
          skip_touch_nxt = 1'b0;
          fin_kind_nxt   = KIND_XLATE;
          fin_addr_nxt   = phys48(w_frame(s_hit_word), off_r);
          fin_ww_nxt     = 1'b0;
          fin_h1_nxt     = 1'b0;
          fin_h2_nxt     = 1'b1;
          state_nxt      = S_INS1;
        end
      end

      S_F1: begin
        fin_kind_nxt = KIND_XLATE;
        fin_addr_nxt = phys48(fill_r, off_r);
        fin_ww_nxt   = 1'b0;
        fin_h1_nxt   = 1'b0;
        fin_h2_nxt   = 1'b0;
        if (s_hit) begin
          w1_en   = 1'b1;
          w1_addr = s_hit_idx[IDX1_W-1:0];
          w1_data = w_pack(1'b1, w_dirty(s_hit_word) | wr_r, w_tag(s_hit_word),
                           fill_r, clock_r);
          sc_go   = 1'b1;
          sc_ret  = S_F2;
        end else begin
          p1_idx_nxt    = s_pick_idx[IDX1_W-1:0];
          p1_word_nxt   = s_pick_word;
          ins_frame_nxt = fill_r;
          ins_dirty_nxt = wr_r;
          state_nxt     = S_INS1;
        end
      end

      S_INS1: begin
        if (w_valid(p1_word_r)) begin
          sc_go  = 1'b1;
          sc_key = w_tag(p1_word_r);
          sc_ret = S_PUSH;
        end else begin
          w1_en = 1'b1;
          if (op_r == CMD_XLATE) begin
            state_nxt = S_TOUCH;
          end else begin
            sc_go  = 1'b1;
            sc_ret = S_F2;
          end
        end
      end

      S_PUSH: begin
        if (!wb || out_free) begin
          em_req = wb;
          w2_en  = 1'b1;
          if (s_hit) begin
            w2_addr = s_hit_idx[IDX2_W-1:0];
            w2_data = w_pack(1'b1, w_dirty(s_hit_word) | w_dirty(p1_word_r),
                             w_tag(s_hit_word), w_frame(p1_word_r), clock_r);
          end else begin
            w2_addr = s_pick_idx[IDX2_W-1:0];
            w2_data = w_pack(1'b1, w_dirty(p1_word_r), w_tag(p1_word_r),
                             w_frame(p1_word_r), clock_r);
          end
          skip_touch_nxt = !s_hit && (s_pick_idx[IDX2_W-1:0] == j_idx_r);
          w1_en = 1'b1;
          if (op_r == CMD_XLATE) begin
            state_nxt = S_TOUCH;
          end else begin
            sc_go  = 1'b1;
            sc_ret = S_F2;
          end
        end
      end

      S_TOUCH: begin
        w2_en     = !skip_touch_r;
        w2_data   = {j_word_r[WORD_W-1:STAMP_W], clock_r};
        state_nxt = S_DONE;
      end

      S_F2: begin
        if (!wb || out_free) begin
          em_req = wb;
          w2_en  = 1'b1;
          if (s_hit) begin
            w2_addr = s_hit_idx[IDX2_W-1:0];
            w2_data = w_pack(1'b1, w_dirty(s_hit_word) | wr_r, w_tag(s_hit_word),
                             fill_r, clock_r);
          end else begin
            w2_addr = s_pick_idx[IDX2_W-1:0];
            w2_data = w_pack(1'b1, wr_r, tag_r, fill_r, clock_r);
          end
          state_nxt = S_DONE;
        end
      end

      S_V1: begin
        sc_go  = 1'b1;
        sc_ret = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          em_req    = 1'b1;
          em_kind   = fin_kind_r;
          em_addr   = fin_addr_r;
          em_ww     = fin_ww_r;
          em_h1     = fin_h1_r;
          em_h2     = fin_h2_r;
          em_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (sc_go) begin
      lvl_nxt   = sc_lvl;
      key_nxt   = sc_key;
      ret_nxt   = sc_ret;
      cnt_nxt   = '0;
      state_nxt = S_SCAN;
    end

    // Output register: a word is loaded only when the slot is free.
    if (em_req) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = em_kind;
      out_addr_nxt  = em_addr;
      out_ww_nxt    = em_ww;
      out_h1_nxt    = em_h1;
      out_h2_nxt    = em_h2;
      out_last_nxt  = em_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dv_r        <= dv_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r        <= ret_nxt;
    op_r         <= op_nxt;
    lvl_r        <= lvl_nxt;
    key_r        <= key_nxt;
    di_r         <= di_nxt;
    tag_r        <= tag_nxt;
    off_r        <= off_nxt;
    va_r         <= va_nxt;
    wr_r         <= wr_nxt;
    fill_r       <= fill_nxt;
    p1_idx_r     <= p1_idx_nxt;
    p1_word_r    <= p1_word_nxt;
    j_idx_r      <= j_idx_nxt;
    j_word_r     <= j_word_nxt;
    ins_frame_r  <= ins_frame_nxt;
    ins_dirty_r  <= ins_dirty_nxt;
    skip_touch_r <= skip_touch_nxt;
    fin_kind_r   <= fin_kind_nxt;
    fin_addr_r   <= fin_addr_nxt;
    fin_ww_r     <= fin_ww_nxt;
    fin_h1_r     <= fin_h1_nxt;
    fin_h2_r     <= fin_h2_nxt;
    out_kind_r   <= out_kind_nxt;
    out_addr_r   <= out_addr_nxt;
    out_ww_r     <= out_ww_nxt;
    out_h1_r     <= out_h1_nxt;
    out_h2_r     <= out_h2_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_address    = out_addr_r;
  assign out_walk_write = out_ww_r;
  assign out_hit_first  = out_h1_r;
  assign out_hit_second = out_h2_r;
  assign out_last       = out_last_r;

endmodule

FILE: design/tlblru_checker.sv
// Port-level checker of the two-level TLB and its bind to the top level.
module tlblru_checker import tlblru_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [47:0] out_address,
  input logic        out_hit_first,
  input logic        out_hit_second,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_address) && $stable(out_kind))
    else $error("result word changed while stalled");

  a_walk_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_WALK |-> out_last)
    else $error("walk request is not the only result of its word");

  a_wb_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_WB |-> !out_last)
    else $error("write-back marked as final result");

  a_one_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit_first && out_hit_second))
    else $error("hit reported in both levels");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("new input taken before the current word finished");

endmodule

bind two_level_tlb_lru_writeback tlblru_checker u_tlblru_checker (.*);

FILE: tb/tlb_checker.sv
// Checker that predicts the two-level TLB results from accepted input words and compares them.
module tlb_checker import tlblru_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [47:0] in_virt_addr,
  input  logic        in_is_write,
  input  logic [27:0] in_fill_page,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [47:0] out_address,
  input  logic        out_walk_write,
  input  logic        out_hit_first,
  input  logic        out_hit_second,
  input  logic        out_last,
  output int          errors,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int L1N = FIRST_ENTRIES_DEF;
  localparam int L2N = SECOND_ENTRIES_DEF;
  localparam int PB  = PAGE_BITS_DEF;
  localparam int PHB = PHYS_BITS_DEF;

  typedef struct packed {
    kind_t       kind;
    logic [47:0] address;
    logic        walk_write;
    logic        hit_first;
    logic        hit_second;
    logic        last;
  } tlb_result_t;

  typedef struct {
    bit          valid;
    bit          dirty;
    bit [35:0]   tag;
    bit [27:0]   frame;
    bit [63:0]   stamp;
  } slot_t;

  slot_t       l1 [L1N];
  slot_t       l2 [L2N];
  bit [63:0]   now;
  tlb_result_t expected_results[$];
  tlb_result_t item_results[$];

  assign pending = expected_results.size();

  function automatic bit [47:0] phys_of(bit [27:0] frame, bit [11:0] off);
    bit [63:0] a;
    a = ({36'd0, frame} << PB) | off;
    return a[47:0] & ((48'd1 << PHB) - 1);
  endfunction

  function automatic void push_result(kind_t k, bit [47:0] a, bit ww, bit h1, bit h2);
    tlb_result_t r;
    r = '{kind: k, address: a, walk_write: ww, hit_first: h1, hit_second: h2, last: 1'b0};
    if (item_results.size() < 3) item_results.push_back(r);
  endfunction

  function automatic int find_l1(bit [35:0] tag);
    for (int i = 0; i < L1N; i++) if (l1[i].valid && l1[i].tag == tag) return i;
    return -1;
  endfunction

  function automatic int find_l2(bit [35:0] tag);
    for (int i = 0; i < L2N; i++) if (l2[i].valid && l2[i].tag == tag) return i;
    return -1;
  endfunction

  function automatic int lru_l1();
    int best;
    best = 0;
    for (int i = 0; i < L1N; i++) begin
      if (!l1[i].valid) return i;
      if (l1[i].stamp < l1[best].stamp) best = i;
    end
    return best;
  endfunction

  function automatic int lru_l2();
    int best;
    best = 0;
    for (int i = 0; i < L2N; i++) begin
      if (!l2[i].valid) return i;
      if (l2[i].stamp < l2[best].stamp) best = i;
    end
    return best;
  endfunction

  // Replacing a valid dirty L2 slot writes its frame back first.
  function automatic void replace_l2(int k, bit [35:0] tag, bit [27:0] frame, bit dirty);
    if (l2[k].valid && l2[k].dirty) push_result(KIND_WB, phys_of(l2[k].frame, 12'd0), 0, 0, 0);
    l2[k] = '{valid: 1'b1, dirty: dirty, tag: tag, frame: frame, stamp: now};
  endfunction

  function automatic void fold_into_l2(bit [35:0] tag, bit [27:0] frame, bit dirty);
    int j;
    j = find_l2(tag);
    if (j >= 0) begin
      l2[j].dirty = l2[j].dirty | dirty;
      l2[j].frame = frame;
      l2[j].stamp = now;
    end else begin
      replace_l2(lru_l2(), tag, frame, dirty);
    end
  endfunction

  function automatic void install_l1(bit [35:0] tag, bit [27:0] frame, bit dirty);
    int i;
    i = find_l1(tag);
    if (i >= 0) begin
      l1[i].frame = frame;
      l1[i].dirty = l1[i].dirty | dirty;
      l1[i].stamp = now;
      return;
    end
    i = lru_l1();
    if (l1[i].valid) fold_into_l2(l1[i].tag, l1[i].frame, l1[i].dirty);
    l1[i] = '{valid: 1'b1, dirty: dirty, tag: tag, frame: frame, stamp: now};
  endfunction

  function automatic void predict_word(cmd_t cmd, bit [47:0] va, bit wr, bit [27:0] fill);
    bit [35:0] tag;
    bit [11:0] off;
    bit [27:0] frame;
    int i;
    tag = va[47:12];
    off = va[11:0];
    item_results.delete();
    if (cmd == CMD_NONE) return;
    now++;
    case (cmd)
      CMD_XLATE: begin
        i = find_l1(tag);
        if (i >= 0) begin
          if (wr) l1[i].dirty = 1'b1;
          l1[i].stamp = now;
          push_result(KIND_XLATE, phys_of(l1[i].frame, off), 0, 1, 0);
        end else begin
          i = find_l2(tag);
          if (i >= 0) begin
            frame = l2[i].frame;
            install_l1(tag, frame, l2[i].dirty | wr);
            // The slot may have been overwritten by the pushed victim; it is stamped anyway.
            l2[i].stamp = now;
            push_result(KIND_XLATE, phys_of(frame, off), 0, 0, 1);
          end else begin
            push_result(KIND_WALK, va, wr, 0, 0);
          end
        end
      end
      CMD_INVAL: begin
        for (int k = 0; k < L1N; k++) if (l1[k].valid && l1[k].tag == tag) l1[k].valid = 0;
        for (int k = 0; k < L2N; k++) if (l2[k].valid && l2[k].tag == tag) l2[k].valid = 0;
        push_result(KIND_INV_DONE, 48'd0, 0, 0, 0);
      end
      default: begin
        install_l1(tag, fill, wr);
        i = find_l2(tag);
        if (i >= 0) begin
          l2[i].frame = fill;
          l2[i].dirty = l2[i].dirty | wr;
          l2[i].stamp = now;
        end else begin
          replace_l2(lru_l2(), tag, fill, wr);
        end
        push_result(KIND_XLATE, phys_of(fill, off), 0, 0, 0);
      end
    endcase
    item_results[item_results.size() - 1].last = 1'b1;
    foreach (item_results[n]) expected_results.push_back(item_results[n]);
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: result mismatch: %s", $realtime, what);
    errors++;
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
    now = '0;
    foreach (l1[i]) l1[i] = '{default: '0};
    foreach (l2[i]) l2[i] = '{default: '0};
  end

  always @(posedge clk) begin
    tlb_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind %0d addr %h", out_kind, out_address));
        end else begin
          want = expected_results.pop_front();
          if (out_kind != want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
          if (out_address != want.address)
            report_mismatch($sformatf("address %h, want %h", out_address, want.address));
          if (out_walk_write != want.walk_write)
            report_mismatch($sformatf("walk_write %0b, want %0b", out_walk_write, want.walk_write));
          if (out_hit_first != want.hit_first)
            report_mismatch($sformatf("hit_first %0b, want %0b", out_hit_first, want.hit_first));
          if (out_hit_second != want.hit_second)
            report_mismatch($sformatf("hit_second %0b, want %0b", out_hit_second, want.hit_second));
          if (out_last != want.last)
            report_mismatch($sformatf("last %0b, want %0b", out_last, want.last));
        end
      end
      if (in_valid && in_ready)
        predict_word(cmd_t'(in_cmd), in_virt_addr, in_is_write, in_fill_page);
    end
  end

endmodule

FILE: tb/tb_two_level_tlb_lru_writeback.sv
// Testbench top for the two-level TLB: stimulus, handshakes, timeout and final verdict.
module tb_two_level_tlb_lru_writeback;
  import tlblru_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic [47:0] in_virt_addr;
  logic        in_is_write;
  logic [27:0] in_fill_page;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [47:0] out_address;
  logic        out_walk_write;
  logic        out_hit_first;
  logic        out_hit_second;
  logic        out_last;

  int errors;
  int pending;
  int results_seen;
  int words_sent;
  longint cycle_count;
  bit stim_done;

  // The slowest word is a fill with up to three results, each stalled by the
  // receiver, plus a random sender gap. About 120 words are sent, so the limit
  // is far beyond a correct run.
  localparam longint CYCLE_LIMIT = 2_000_000;

  // A small pool of page numbers keeps hits, promotions and evictions frequent.
  // Forty pages overflow the 16-entry first level while fitting the second one;
  // a sweep through many more pages later forces second-level replacement.
  bit [35:0] page_pool[40];

  two_level_tlb_lru_writeback u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_virt_addr(in_virt_addr), .in_is_write(in_is_write), .in_fill_page(in_fill_page),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_address(out_address), .out_walk_write(out_walk_write),
    .out_hit_first(out_hit_first), .out_hit_second(out_hit_second), .out_last(out_last)
  );

  tlb_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_virt_addr(in_virt_addr), .in_is_write(in_is_write), .in_fill_page(in_fill_page),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_address(out_address), .out_walk_write(out_walk_write),
    .out_hit_first(out_hit_first), .out_hit_second(out_hit_second), .out_last(out_last),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The cycle counter is the only timeout; it ends the run with the fail verdict.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected", cycle_count, pending);
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver holds out_ready low for a random stall before taking each word.
  // Every fourth word or so the stall is zero, which gives unstalled stretches.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      repeat (stall) @(negedge clk);
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
      out_ready <= 1'b0;
    end
  end

  // Presents one word and holds it until the block takes it; the gap before it
  // is random so that idle cycles fall on every phase of the scan. Valid is
  // dropped only when a gap follows, so a word with no gap takes over directly.
  task automatic send_word(cmd_t cmd, bit [47:0] va, bit wr, bit [27:0] fill);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cmd       <= cmd;
    in_virt_addr <= va;
    in_is_write  <= wr;
    in_fill_page <= fill;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
  endtask

  function automatic bit [47:0] addr_of(bit [35:0] page);
    return {page, 12'(($urandom()))};
  endfunction

  // A translation of a page is followed, in about eight of ten cases, by a fill of that page, hit or miss.
  task automatic access_page(bit [35:0] page, bit wr);
    bit [47:0] va;
    va = addr_of(page);
    send_word(CMD_XLATE, va, wr, 28'd0);
    if ($urandom_range(0, 9) < 8)
      send_word(CMD_FILL, addr_of(page), $urandom_range(0, 1), 28'($urandom()));
  endtask

  initial begin
    int choice;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_cmd       = CMD_XLATE;
    in_virt_addr = '0;
    in_is_write  = 1'b0;
    in_fill_page = '0;
    cycle_count  = 0;
    words_sent   = 0;
    stim_done    = 1'b0;
    foreach (page_pool[i]) page_pool[i] = {$urandom(), 4'($urandom())};
    page_pool[0] = '0;
    page_pool[1] = '1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words: extreme addresses and frames, each command, the ignored
    // command, a miss, fills, hits in both levels and invalidation.
    send_word(CMD_XLATE, 48'h0, 1'b0, 28'h0);
    send_word(CMD_FILL,  48'h0, 1'b0, 28'h0);
    send_word(CMD_XLATE, 48'h0000_0000_0FFF, 1'b1, 28'h0);
    send_word(CMD_XLATE, 48'hFFFF_FFFF_FFFF, 1'b1, 28'hFFF_FFFF);
    send_word(CMD_FILL,  48'hFFFF_FFFF_F000, 1'b1, 28'hFFF_FFFF);
    send_word(CMD_XLATE, 48'hFFFF_FFFF_FABC, 1'b0, 28'h0);
    send_word(CMD_NONE,  48'hFFFF_FFFF_FFFF, 1'b1, 28'hFFF_FFFF);
    send_word(CMD_FILL,  48'hAAAA_5555_A5A5, 1'b0, 28'hA5A_5A5A);
    send_word(CMD_FILL,  48'h5555_AAAA_5A5A, 1'b1, 28'h5A5_A5A5);
    send_word(CMD_INVAL, 48'hFFFF_FFFF_F123, 1'b0, 28'h0);
    send_word(CMD_XLATE, 48'hFFFF_FFFF_F123, 1'b0, 28'h0);
    // Seventeen fills overflow the first level so that page zero is promoted back.
    for (int p = 1; p <= 17; p++) send_word(CMD_FILL, {36'(p * 3 + 7), 12'h0}, p[0], 28'(p));
    send_word(CMD_XLATE, 48'h0000_0000_0321, 1'b1, 28'h0);
    send_word(CMD_INVAL, 48'h0000_0000_0000, 1'b1, 28'h0);

    // Random part: mostly translate and fill over a page pool, plus noise.
    for (int n = 0; n < 48; n++) begin
      choice = $urandom_range(0, 19);
      if (choice < 12)
        access_page(page_pool[$urandom_range(0, 39)], $urandom_range(0, 1));
      else if (choice < 14)
        send_word(CMD_INVAL, addr_of(page_pool[$urandom_range(0, 39)]), $urandom_range(0, 1),
                  28'($urandom()));
      else if (choice < 15)
        send_word(CMD_NONE, {$urandom(), 16'($urandom())}, $urandom_range(0, 1), 28'($urandom()));
      else if (choice < 17)
        send_word(cmd_t'($urandom_range(0, 2)), {$urandom(), 16'($urandom())},
                  $urandom_range(0, 1), 28'($urandom()));
      else
        // A burst of fresh pages with write fills pushes dirty entries out of the second level.
        for (int b = 0; b < 4; b++)
          send_word(CMD_FILL, {$urandom(), 16'($urandom())}, 1'b1, 28'($urandom()));
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    while (pending != 0) @(posedge clk);
    // Allow the longest scan to finish in case a stray word would still appear.
    repeat (400) @(posedge clk);
    $display("Sent %0d input words and checked %0d result words.", words_sent, results_seen);
    $display("Covered hits in both levels, promotions, walks, fills, invalidates and write-backs.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
